// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the divide, modulo and power RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/idmp_pkg.sv =====
// Package with the operation codes, status codes and sequencer states of the unit.
package idmp_pkg;

  localparam logic [1:0] MODE_DIV = 2'd0;
  localparam logic [1:0] MODE_MOD = 2'd1;
  localparam logic [1:0] MODE_POW = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_ZERO_DIV = 2'd1;
  localparam logic [1:0] STAT_NEG_EXP  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_DFIN,
    S_POW,
    S_MACC,
    S_MSQ,
    S_DONE
  } state_t;

endpackage

// ===== hdl/int64_div_mod_pow_unit.sv =====
// Signed divide, modulo and power unit: one item in, one result item out, computed at
// WORD_WIDTH bits and sign-extended to 64. Divide and modulo run a restoring divider that
// settles one quotient bit per cycle. Power runs square-and-multiply on one shared
// half-width multiplier, one wrapped word product at a time. A zero divisor, a negative
// exponent and an unused mode skip the computation and go straight to the done state.
// The input is held off while an item is in work; a finished result sits in the output
// register, so the next item can be accepted before it is taken.
`include "assert_macros.svh"

module int64_div_mod_pow_unit #(
  parameter int WORD_WIDTH = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // operand_a [63:0], operand_b [127:64]
  input  logic [1:0]   s_tuser,   // mode [1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata,   // result [63:0]
  output logic [1:0]   m_tuser    // status [1:0]
);
  import idmp_pkg::*;

  localparam int CW = $clog2(WORD_WIDTH);

  state_t state;
  state_t state_next;

  logic [WORD_WIDTH-1:0]        a_w;
  logic [WORD_WIDTH-1:0]        b_w;
  logic [WORD_WIDTH-1:0]        a_mag;
  logic [WORD_WIDTH-1:0]        b_mag;
  logic                         b_zero;

  logic [WORD_WIDTH-1:0]        quot;
  logic [WORD_WIDTH-1:0]        rem;
  logic [WORD_WIDTH-1:0]        ub;
  logic [CW-1:0]                cnt;
  logic                         is_mod;
  logic                         a_neg;
  logic                         q_neg;
  logic [WORD_WIDTH:0]          shifted;
  logic [WORD_WIDTH:0]          diff;
  logic                         fits;

  logic [WORD_WIDTH-1:0]        acc;
  logic [WORD_WIDTH-1:0]        base;
  logic [WORD_WIDTH-1:0]        expo;

  logic signed [WORD_WIDTH-1:0] res;
  logic [1:0]                   stat;
  logic                         out_free;

  logic                         mul_start;
  logic [WORD_WIDTH-1:0]        mul_x;
  logic [WORD_WIDTH-1:0]        mul_y;
  logic [WORD_WIDTH-1:0]        mul_prod;
  logic                         mul_done;

  idmp_mul #(
    .WORD_WIDTH(WORD_WIDTH)
  ) u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .x    (mul_x),
    .y    (mul_y),
    .prod (mul_prod),
    .done (mul_done)
  );

  assign a_w    = s_tdata[WORD_WIDTH-1:0];
  assign b_w    = s_tdata[64+WORD_WIDTH-1:64];
  assign a_mag  = a_w[WORD_WIDTH-1] ? (WORD_WIDTH'(0) - a_w) : a_w;
  assign b_mag  = b_w[WORD_WIDTH-1] ? (WORD_WIDTH'(0) - b_w) : b_w;
  assign b_zero = (b_w == '0);

  // Restoring step: the partial remainder stays below the divisor, so one spare bit suffices.
  assign shifted = {rem, quot[WORD_WIDTH-1]};
  assign diff    = shifted - {1'b0, ub};
  assign fits    = (shifted >= {1'b0, ub});

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // The multiply issued from the power state is acc * base when the exponent bit is set.
  assign mul_x = ((state == S_POW) && expo[0]) ? acc : base;
  assign mul_y = base;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          unique case (s_tuser) inside
            MODE_DIV, MODE_MOD: state_next = b_zero ? S_DONE : S_DIV;
            MODE_POW:           state_next = b_w[WORD_WIDTH-1] ? S_DONE : S_POW;
            default:            state_next = S_DONE;
          endcase
        end
      end
      S_DIV: begin
        if (cnt == CW'(WORD_WIDTH - 1)) begin
          state_next = S_DFIN;
        end
      end
      S_DFIN: state_next = S_DONE;
      S_POW: begin
        if (expo == '0) begin
          state_next = S_DONE;
        end else begin
          mul_start  = 1'b1;
          state_next = expo[0] ? S_MACC : S_MSQ;
        end
      end
      S_MACC: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          state_next = S_MSQ;
        end
      end
      S_MSQ: begin
        if (mul_done) begin
          state_next = S_POW;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          res <= '0;
          case (s_tuser) inside
            MODE_DIV, MODE_MOD: begin
              stat   <= b_zero ? STAT_ZERO_DIV : STAT_OK;
              quot   <= a_mag;
              ub     <= b_mag;
              rem    <= '0;
              cnt    <= '0;
              is_mod <= (s_tuser == MODE_MOD);
              a_neg  <= a_w[WORD_WIDTH-1];
              q_neg  <= a_w[WORD_WIDTH-1] ^ b_w[WORD_WIDTH-1];
            end
            MODE_POW: begin
              stat <= b_w[WORD_WIDTH-1] ? STAT_NEG_EXP : STAT_OK;
              acc  <= WORD_WIDTH'(1);
              base <= a_w;
              expo <= b_w;
            end
            default: begin
              stat <= STAT_OK;
            end
          endcase
        end
      end
      S_DIV: begin
        rem  <= fits ? diff[WORD_WIDTH-1:0] : shifted[WORD_WIDTH-1:0];
        quot <= {quot[WORD_WIDTH-2:0], fits};
        cnt  <= cnt + CW'(1);
      end
      S_DFIN: begin
        if (is_mod) begin
          res <= a_neg ? (WORD_WIDTH'(0) - rem) : rem;
        end else begin
          res <= q_neg ? (WORD_WIDTH'(0) - quot) : quot;
        end
      end
      S_POW: begin
        if (expo == '0) begin
          res <= acc;
        end
      end
      S_MACC: begin
        if (mul_done) begin
          acc <= mul_prod;
        end
      end
      S_MSQ: begin
        if (mul_done) begin
          base <= mul_prod;
          expo <= expo >> 1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      m_tdata <= 64'(res);
      m_tuser <= stat;
    end
  end

  `ASSERT_NXT(a_accept_leaves_idle, s_tvalid && s_tready, state != S_IDLE, "item not started")
  `ASSERT_IMP(a_err_zero, m_tvalid && (m_tuser != STAT_OK), m_tdata == '0, "nonzero error result")
  `ASSERT_IMP(a_mul_seq, mul_done, (state == S_MACC) || (state == S_MSQ), "stray multiply done")

endmodule

// ===== hdl/idmp_mul.sv =====
// Wrapping word multiplier built from one half-width multiplier that forms the partial products in turn.
`include "assert_macros.svh"

module idmp_mul #(
  parameter int WORD_WIDTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [WORD_WIDTH-1:0] x,
  input  logic [WORD_WIDTH-1:0] y,
  output logic [WORD_WIDTH-1:0] prod,
  output logic                  done
);
  import idmp_pkg::*;

  localparam int HW = (WORD_WIDTH + 1) / 2;

  localparam logic [1:0] PH_LL  = 2'd0;
  localparam logic [1:0] PH_HL  = 2'd1;
  localparam logic [1:0] PH_LH  = 2'd2;
  localparam logic [1:0] PH_END = 2'd3;

  logic [WORD_WIDTH-1:0] xr;
  logic [WORD_WIDTH-1:0] yr;
  logic [WORD_WIDTH-1:0] acc;
  logic [2*HW-1:0]       preg;
  logic [1:0]            cnt;
  logic                  busy;

  logic [HW-1:0]         ma;
  logic [HW-1:0]         mb;
  logic [2*HW-1:0]       mprod;
  logic [WORD_WIDTH-1:0] pshift;

  // Only the low word of the product is kept, so the high-by-high term drops out.
  always_comb begin
    case (cnt)
      PH_LL: begin
        ma = xr[HW-1:0];
        mb = yr[HW-1:0];
      end
      PH_HL: begin
        ma = HW'(xr[WORD_WIDTH-1:HW]);
        mb = yr[HW-1:0];
      end
      default: begin
        ma = xr[HW-1:0];
        mb = HW'(yr[WORD_WIDTH-1:HW]);
      end
    endcase
  end

  assign mprod  = ma * mb;
  assign pshift = preg[WORD_WIDTH-1:0] << HW;
  assign prod   = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= PH_LL;
    end else begin
      done <= busy && (cnt == PH_END);
      if (start) begin
        busy <= 1'b1;
        cnt  <= PH_LL;
      end else if (busy) begin
        cnt <= cnt + 2'd1;
        if (cnt == PH_END) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xr <= x;
      yr <= y;
    end
    if (busy) begin
      preg <= mprod;
      case (cnt) inside
        PH_HL:         acc <= preg[WORD_WIDTH-1:0];
        PH_LH, PH_END: acc <= acc + pshift;
        default:       acc <= acc;
      endcase
    end
  end

  `ASSERT_IMP(a_start_idle, start, !busy, "multiply started while busy")
  `ASSERT_NXT(a_done_after_last, busy && (cnt == PH_END), done && !busy, "missing multiply done")

endmodule

// ===== dv/tb_int64_div_mod_pow_unit.sv =====
// Self-checking testbench for the signed divide, modulo and power unit.
module tb_int64_div_mod_pow_unit;
  import idmp_pkg::*;

  localparam logic [1:0]  MODE_UNUSED  = 2'd3;
  localparam logic [63:0] W_MIN        = 64'h8000_0000_0000_0000;
  localparam logic [63:0] W_MAX        = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] W_NEG1       = 64'hffff_ffff_ffff_ffff;
  localparam int          STALL_LIMIT  = 20000;
  localparam int          DRAIN_CYCLES = 800;
  localparam int          HOLD_CYCLES  = 400;

  typedef struct packed {
    logic [63:0] result;
    logic [1:0]  status;
  } idmp_result_t;

  logic         clk;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;   // operand_a [63:0], operand_b [127:64]
  logic [1:0]   s_tuser = '0;   // mode [1:0]
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [63:0]  m_tdata;        // result [63:0]
  logic [1:0]   m_tuser;        // status [1:0]

  idmp_result_t expected_results[$];
  int           tx_idle_pct = 0;
  int           rx_idle_pct = 0;
  int           hold_len = 0;
  int           stall_cycles = 0;
  int           failures = 0;

  int64_div_mod_pow_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic idmp_result_t predict_result(input logic [1:0] mode,
                                                  input logic [63:0] a,
                                                  input logic [63:0] b);
    idmp_result_t r;
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [63:0]  q;
    logic [63:0]  rem;
    logic [63:0]  acc;
    logic [63:0]  base;
    logic [63:0]  e;
    r.result = '0;
    r.status = STAT_OK;
    case (mode)
      MODE_DIV, MODE_MOD: begin
        if (b == '0) begin
          r.status = STAT_ZERO_DIV;
        end else if (b == W_NEG1) begin
          r.result = (mode == MODE_DIV) ? -a : '0;
        end else begin
          ua = a[63] ? -a : a;
          ub = b[63] ? -b : b;
          if (mode == MODE_DIV) begin
            q = ua / ub;
            r.result = (a[63] ^ b[63]) ? -q : q;
          end else begin
            rem = ua % ub;
            r.result = a[63] ? -rem : rem;
          end
        end
      end
      MODE_POW: begin
        if (b[63]) begin
          r.status = STAT_NEG_EXP;
        end else begin
          acc = 64'd1;
          base = a;
          e = b;
          while (e != '0) begin
            if (e[0]) acc = acc * base;
            base = base * base;
            e = e >> 1;
          end
          r.result = acc;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Both handshakes are sampled here so that the prediction is queued before any
  // result of the same edge is compared.
  always @(posedge clk) begin
    idmp_result_t want;
    if (!rst) begin
      if (s_tvalid && s_tready)
        expected_results.push_back(predict_result(s_tuser, s_tdata[63:0], s_tdata[127:64]));
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result item: result %h status %0d", m_tdata, m_tuser);
          failures++;
        end else begin
          want = expected_results.pop_front();
          if (m_tdata !== want.result) begin
            $error("result mismatch: expected %h, actual %h", want.result, m_tdata);
            failures++;
          end
          if (m_tuser !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, m_tuser);
            failures++;
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("FAIL int64_div_mod_pow_unit");
    $finish;
  end

  // The receiver either sits out a requested hold-off or stalls at random.
  always @(posedge clk) begin
    if (hold_len != 0) begin
      m_tready <= 1'b0;
      hold_len <= hold_len - 1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  task automatic send_item(input logic [1:0] mode, input logic [63:0] a, input logic [63:0] b);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {b, a};
    s_tuser  <= mode;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_operand();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 6))
          0: w = '0;
          1: w = 64'd1;
          2: w = W_NEG1;
          3: w = W_MIN;
          4: w = W_MAX;
          5: w = W_MIN + 64'd1;
          default: w = 64'd2;
        endcase
      end
      1, 2: w = w >> $urandom_range(1, 63);
      3: w = -(w >> $urandom_range(1, 63));
      default: ;
    endcase
    return w;
  endfunction

  // Most exponents are short so that power items stay quick; a few span all 63 bits.
  function automatic logic [63:0] rand_exponent();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: w = 64'($urandom_range(0, 70));
      6: w = w | W_MIN;
      7, 8: w = w >> $urandom_range(40, 63);
      default: w = w & W_MAX;
    endcase
    return w;
  endfunction

  task automatic test_divide_corners();
    send_item(MODE_DIV, W_MIN, W_NEG1);
    send_item(MODE_DIV, W_MAX, W_NEG1);
    send_item(MODE_DIV, W_MIN, 64'd1);
    send_item(MODE_DIV, 64'(-7), 64'd2);
    send_item(MODE_DIV, 64'd7, 64'(-2));
    send_item(MODE_DIV, 64'(-7), 64'(-2));
    send_item(MODE_DIV, 64'd0, 64'(-5));
    send_item(MODE_DIV, 64'd123, 64'd0);
    send_item(MODE_DIV, W_MAX, W_MIN);
  endtask

  task automatic test_modulo_corners();
    send_item(MODE_MOD, 64'(-7), 64'd2);
    send_item(MODE_MOD, 64'd7, 64'(-2));
    send_item(MODE_MOD, W_MIN, W_NEG1);
    send_item(MODE_MOD, W_MIN, W_MAX);
    send_item(MODE_MOD, 64'd5, W_MIN);
    send_item(MODE_MOD, 64'd42, 64'd0);
  endtask

  task automatic test_power_corners();
    send_item(MODE_POW, 64'd0, 64'd0);
    send_item(MODE_POW, 64'd7, 64'd0);
    send_item(MODE_POW, 64'd2, 64'd62);
    send_item(MODE_POW, 64'd2, 64'd64);
    send_item(MODE_POW, 64'd3, W_MAX);
    send_item(MODE_POW, 64'(-2), 64'd63);
    send_item(MODE_POW, 64'd5, W_NEG1);
    send_item(MODE_POW, 64'd2, W_MIN);
  endtask

  task automatic test_unused_mode();
    send_item(MODE_UNUSED, W_MIN, W_MAX);
    send_item(MODE_UNUSED, W_NEG1, 64'd0);
  endtask

  task automatic test_random(input int count, input int tx_pct, input int rx_pct);
    int unsigned pick;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 34)
        send_item(MODE_DIV, rand_operand(), rand_operand());
      else if (pick < 67)
        send_item(MODE_MOD, rand_operand(), rand_operand());
      else if (pick < 95)
        send_item(MODE_POW, rand_operand(), rand_exponent());
      else
        send_item(MODE_UNUSED, rand_operand(), rand_operand());
    end
  endtask

  // The receiver holds off long enough for one result to sit in the output register
  // and another to wait behind it, so the input side has to stall.
  task automatic test_output_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_len <= HOLD_CYCLES;
    repeat (6) send_item($urandom_range(0, 1) ? MODE_DIV : MODE_MOD,
                         rand_operand(), rand_operand());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_divide_corners();
    test_modulo_corners();
    test_power_corners();
    test_unused_mode();
    test_random(510, 8, 57);
    test_random(510, 57, 8);
    test_output_backpressure();
    test_random(510, 0, 0);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && expected_results.size() == 0)
      $display("PASS int64_div_mod_pow_unit");
    else
      $display("FAIL int64_div_mod_pow_unit");
    $finish;
  end

endmodule
